[rtl/core/nblc_pkg.sv]
// Package for the nucleotide bigram line counter: request/result types, codes, helpers.
package nblc_pkg;

    // Default sizes
    localparam int LINE_LEN_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF    = 32;
    localparam int SQ_SUM_WIDTH       = 48;

    // Request modes
    localparam logic [1:0] MODE_CHAR  = 2'd0;
    localparam logic [1:0] MODE_EOL   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Counter index map
    localparam logic [4:0] IDX_PAIR_FIRST  = 5'd4;
    localparam logic [4:0] IDX_PAIR_LAST   = 5'd19;
    localparam logic [4:0] IDX_BASES       = 5'd20;
    localparam logic [4:0] IDX_LINES       = 5'd21;
    localparam logic [4:0] IDX_SQUARES     = 5'd22;

    // Base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_T = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    // Character bytes
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CASE_FOLD = 8'h20;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] text_byte;
        logic [4:0] counter_index;
    } in_req_t;

    typedef struct packed {
        logic        line_valid;
        logic [15:0] line_length;
        logic [47:0] counter_value;
    } out_res_t;

    // Commands from the top level to the line accumulator
    typedef struct packed {
        logic char_en;
        logic eol_en;
    } line_ctrl_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] code;
    } base_dec_t;

    // Fold case and map a byte to a base code
    function automatic base_dec_t base_decode(input logic [7:0] ch);
        base_dec_t  d;
        logic [7:0] up;
        up = ch;
        if (ch >= (CHAR_A | CASE_FOLD) && ch <= 8'h7A) begin
            up = ch - CASE_FOLD;
        end
        d.hit  = 1'b1;
        d.code = BASE_A;
        case (up)
            CHAR_A:  d.code = BASE_A;
            CHAR_C:  d.code = BASE_C;
            CHAR_T:  d.code = BASE_T;
            CHAR_G:  d.code = BASE_G;
            default: d.hit  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

[rtl/core/nblc_line_acc.sv]
// Per-line accumulator: pending base and bigram counts, length, running square, clean flag.
module nblc_line_acc #(
    parameter int LINE_LEN_WIDTH = nblc_pkg::LINE_LEN_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nblc_pkg::line_ctrl_t          ctrl,
    input  logic [7:0]                    text_byte,
    output logic [LINE_LEN_WIDTH-1:0]     line_len,
    output logic [2*LINE_LEN_WIDTH-1:0]   line_sq,
    output logic                          line_ok,
    output logic [LINE_LEN_WIDTH-1:0]     base_cnt [4],
    output logic [LINE_LEN_WIDTH-1:0]     pair_cnt [16]
);

    localparam int W  = LINE_LEN_WIDTH;
    localparam int SW = 2 * LINE_LEN_WIDTH;
    localparam logic [W-1:0] LEN_MAX = {W{1'b1}};

    logic [W-1:0]  len_reg, len_next;
    logic [SW-1:0] sq_reg, sq_next;
    logic [1:0]    held_reg, held_next;
    logic          clean_reg, clean_next;
    logic [W-1:0]  base_reg [4];
    logic [W-1:0]  base_next [4];
    logic [W-1:0]  pair_reg [16];
    logic [W-1:0]  pair_next [16];

    nblc_pkg::base_dec_t dec;
    logic [3:0]          pair_idx;
    logic                take;

    assign dec      = nblc_pkg::base_decode(text_byte);
    assign pair_idx = {held_reg, dec.code};
    // Bytes beyond the saturated length are dropped
    assign take     = ctrl.char_en && (len_reg != LEN_MAX);

    // Next-state for the line in progress
    always_comb begin
        len_next   = len_reg;
        sq_next    = sq_reg;
        held_next  = held_reg;
        clean_next = clean_reg;
        for (int i = 0; i < 4; i++) begin
            base_next[i] = base_reg[i];
        end
        for (int i = 0; i < 16; i++) begin
            pair_next[i] = pair_reg[i];
        end
        if (ctrl.eol_en) begin
            len_next   = '0;
            sq_next    = '0;
            held_next  = nblc_pkg::BASE_A;
            clean_next = 1'b1;
            for (int i = 0; i < 4; i++) begin
                base_next[i] = '0;
            end
            for (int i = 0; i < 16; i++) begin
                pair_next[i] = '0;
            end
        end else if (take) begin
            len_next = len_reg + 1'b1;
            // (n+1)^2 = n^2 + 2n + 1
            sq_next  = sq_reg + SW'({len_reg, 1'b1});
            if (!dec.hit) begin
                clean_next = 1'b0;
            end else begin
                if (base_reg[dec.code] != LEN_MAX) begin
                    base_next[dec.code] = base_reg[dec.code] + 1'b1;
                end
                if (!len_reg[0]) begin
                    held_next = dec.code;
                end else if (pair_reg[pair_idx] != LEN_MAX) begin
                    pair_next[pair_idx] = pair_reg[pair_idx] + 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            sq_reg    <= '0;
            held_reg  <= nblc_pkg::BASE_A;
            clean_reg <= 1'b1;
            for (int i = 0; i < 4; i++) begin
                base_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++) begin
                pair_reg[i] <= '0;
            end
        end else begin
            len_reg   <= len_next;
            sq_reg    <= sq_next;
            held_reg  <= held_next;
            clean_reg <= clean_next;
            for (int i = 0; i < 4; i++) begin
                base_reg[i] <= base_next[i];
            end
            for (int i = 0; i < 16; i++) begin
                pair_reg[i] <= pair_next[i];
            end
        end
    end

    // Line acceptance: clean, non-empty, even, not saturated
    assign line_ok  = clean_reg && (len_reg != '0) && !len_reg[0] && (len_reg != LEN_MAX);
    assign line_len = len_reg;
    assign line_sq  = sq_reg;
    assign base_cnt = base_reg;
    assign pair_cnt = pair_reg;

endmodule

[rtl/core/nucleotide_bigram_line_counter.sv]
// Top level of the nucleotide bigram line counter: handshake, totals, readback.
//
// Takes one request per cycle when results are drained. Characters and clears
// keep flowing while a result waits on m_ready; an end of line or a read waits
// in the input register until the result register is free or being emptied
// in the same cycle. Character, end-of-line commit, counter read and clear are
// each finished as the request leaves the input register; for requests that
// return a result (end of line, read), the result register is loaded at that
// point and drives m_valid. The line-end commit adds all twenty pending base and
// bigram counts into their saturating totals in parallel;
// the squared line length is kept as a running sum per character, so no
// multiplier sits in the commit path. Characters and clears return nothing.
// Totals need no clearing pass after reset.
module nucleotide_bigram_line_counter #(
    parameter int LINE_LEN_WIDTH = nblc_pkg::LINE_LEN_WIDTH_DEF,
    parameter int COUNT_WIDTH    = nblc_pkg::COUNT_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nblc_pkg::in_req_t  s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output nblc_pkg::out_res_t m_res
);

    localparam int W    = LINE_LEN_WIDTH;
    localparam int C    = COUNT_WIDTH;
    localparam int SW   = 2 * LINE_LEN_WIDTH;
    localparam int QW   = nblc_pkg::SQ_SUM_WIDTH;
    localparam int CSUM = ((W > C) ? W : C) + 1;
    localparam int QSUM = ((SW > QW) ? SW : QW) + 1;
    localparam logic [C-1:0]    CNT_MAX  = {C{1'b1}};
    localparam logic [QW-1:0]   SQ_MAX   = {QW{1'b1}};
    localparam logic [CSUM-1:0] CNT_MAXX = CSUM'(CNT_MAX);
    localparam logic [QSUM-1:0] SQ_MAXX  = QSUM'(SQ_MAX);

    // Input register
    logic              in_valid_reg;
    nblc_pkg::in_req_t in_req_reg;
    // Result register
    logic               out_valid_reg, out_valid_next;
    nblc_pkg::out_res_t out_res_reg, out_res_next;

    // Totals
    logic [C-1:0]  base_tot_reg [4];
    logic [C-1:0]  base_tot_next [4];
    logic [C-1:0]  pair_tot_reg [16];
    logic [C-1:0]  pair_tot_next [16];
    logic [C-1:0]  bases_reg, bases_next;
    logic [C-1:0]  lines_reg, lines_next;
    logic [QW-1:0] sq_sum_reg, sq_sum_next;

    logic                 produces;
    logic                 advance;
    nblc_pkg::line_ctrl_t line_ctrl;

    logic [W-1:0]  line_len;
    logic [SW-1:0] line_sq;
    logic          line_ok;
    logic [W-1:0]  base_cnt [4];
    logic [W-1:0]  pair_cnt [16];

    logic [CSUM-1:0] csum_base [4];
    logic [CSUM-1:0] csum_pair [16];
    logic [CSUM-1:0] csum_bases;
    logic [CSUM-1:0] csum_lines;
    logic [QSUM-1:0] qsum;
    logic [C-1:0]    read_cnt;
    logic [QW-1:0]   read_val;
    logic [3:0]      read_pair;

    // Handshake: stage moves when its result slot is free, being emptied or not needed
    assign produces = (in_req_reg.mode == nblc_pkg::MODE_EOL) ||
                      (in_req_reg.mode == nblc_pkg::MODE_READ);
    assign advance  = in_valid_reg && (!produces || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_res_reg;

    assign line_ctrl.char_en = advance && (in_req_reg.mode == nblc_pkg::MODE_CHAR);
    assign line_ctrl.eol_en  = advance && (in_req_reg.mode == nblc_pkg::MODE_EOL);

    nblc_line_acc #(
        .LINE_LEN_WIDTH(LINE_LEN_WIDTH)
    ) u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (line_ctrl),
        .text_byte (in_req_reg.text_byte),
        .line_len  (line_len),
        .line_sq   (line_sq),
        .line_ok   (line_ok),
        .base_cnt  (base_cnt),
        .pair_cnt  (pair_cnt)
    );

    // Widened sums for a saturating line commit
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            csum_base[i] = CSUM'(base_tot_reg[i]) + CSUM'(base_cnt[i]);
        end
        for (int i = 0; i < 16; i++) begin
            csum_pair[i] = CSUM'(pair_tot_reg[i]) + CSUM'(pair_cnt[i]);
        end
        csum_bases = CSUM'(bases_reg) + CSUM'(line_len);
        csum_lines = CSUM'(lines_reg) + CSUM'(1'b1);
        qsum       = QSUM'(sq_sum_reg) + QSUM'(line_sq);
    end

    // Totals next-state
    always_comb begin
        base_tot_next = base_tot_reg;
        pair_tot_next = pair_tot_reg;
        bases_next    = bases_reg;
        lines_next    = lines_reg;
        sq_sum_next   = sq_sum_reg;
        if (advance && in_req_reg.mode == nblc_pkg::MODE_CLEAR) begin
            for (int i = 0; i < 4; i++) begin
                base_tot_next[i] = '0;
            end
            for (int i = 0; i < 16; i++) begin
                pair_tot_next[i] = '0;
            end
            bases_next  = '0;
            lines_next  = '0;
            sq_sum_next = '0;
        end else if (line_ctrl.eol_en && line_ok) begin
            for (int i = 0; i < 4; i++) begin
                base_tot_next[i] = (csum_base[i] > CNT_MAXX) ? CNT_MAX : C'(csum_base[i]);
            end
            for (int i = 0; i < 16; i++) begin
                pair_tot_next[i] = (csum_pair[i] > CNT_MAXX) ? CNT_MAX : C'(csum_pair[i]);
            end
            bases_next  = (csum_bases > CNT_MAXX) ? CNT_MAX : C'(csum_bases);
            lines_next  = (csum_lines > CNT_MAXX) ? CNT_MAX : C'(csum_lines);
            sq_sum_next = (qsum > SQ_MAXX) ? SQ_MAX : QW'(qsum);
        end
    end

    // Counter readback select
    assign read_pair = 4'(in_req_reg.counter_index - nblc_pkg::IDX_PAIR_FIRST);
    always_comb begin
        read_cnt = '0;
        read_val = '0;
        if (in_req_reg.counter_index < nblc_pkg::IDX_PAIR_FIRST) begin
            read_cnt = base_tot_reg[in_req_reg.counter_index[1:0]];
            read_val = QW'(read_cnt);
        end else if (in_req_reg.counter_index <= nblc_pkg::IDX_PAIR_LAST) begin
            read_cnt = pair_tot_reg[read_pair];
            read_val = QW'(read_cnt);
        end else if (in_req_reg.counter_index == nblc_pkg::IDX_BASES) begin
            read_cnt = bases_reg;
            read_val = QW'(read_cnt);
        end else if (in_req_reg.counter_index == nblc_pkg::IDX_LINES) begin
            read_cnt = lines_reg;
            read_val = QW'(read_cnt);
        end else if (in_req_reg.counter_index == nblc_pkg::IDX_SQUARES) begin
            read_val = sq_sum_reg;
        end
    end

    // Result formation
    always_comb begin
        out_res_next = out_res_reg;
        unique case (in_req_reg.mode)
            nblc_pkg::MODE_EOL: begin
                out_res_next.line_valid    = line_ok;
                out_res_next.line_length   = 16'(line_len);
                out_res_next.counter_value = '0;
            end
            nblc_pkg::MODE_READ: begin
                out_res_next.line_valid    = 1'b0;
                out_res_next.line_length   = '0;
                out_res_next.counter_value = read_val;
            end
            default: begin
                out_res_next = out_res_reg;
            end
        endcase
        if (advance && produces) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg <= s_req;
        end
        if (advance && produces) begin
            out_res_reg <= out_res_next;
        end
    end

    // Totals registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                base_tot_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++) begin
                pair_tot_reg[i] <= '0;
            end
            bases_reg  <= '0;
            lines_reg  <= '0;
            sq_sum_reg <= '0;
        end else begin
            base_tot_reg <= base_tot_next;
            pair_tot_reg <= pair_tot_next;
            bases_reg    <= bases_next;
            lines_reg    <= lines_next;
            sq_sum_reg   <= sq_sum_next;
        end
    end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the nucleotide bigram line counter.
module testbench;
    import nblc_pkg::*;

    localparam int          CYCLE_LIMIT  = 3_000_000;
    localparam int          RANDOM_ITEMS = 1040;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTLE       = 8;
    localparam logic [15:0] LEN_CAP      = 16'hFFFF;
    localparam logic [47:0] CNT_CAP      = 48'h0000_FFFF_FFFF;
    localparam logic [47:0] SQ_CAP       = 48'hFFFF_FFFF_FFFF;
    localparam logic [4:0]  IDX_BEYOND   = 5'd31;

    // One step of the directed plan; want is only used when typed is set
    typedef struct {
        in_req_t  req;
        bit       typed;
        out_res_t want;
    } plan_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    in_req_t  s_req;
    logic     m_valid;
    logic     m_ready;
    out_res_t m_res;

    // Line in progress
    logic [15:0] ln_base_cnt [4];
    logic [15:0] ln_pair_cnt [16];
    logic [15:0] ln_len;
    logic [1:0]  ln_first;
    bit          ln_clean;

    // Running totals
    logic [31:0] tot_base [4];
    logic [31:0] tot_pair [16];
    logic [31:0] tot_len;
    logic [31:0] tot_lines;
    logic [47:0] tot_sq;

    out_res_t owed_reports [$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       sent_items = 0;
    int       burst_left = 0;
    bit       hold_ask = 1'b0;

    nucleotide_bigram_line_counter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Saturating add; a never exceeds cap
    function automatic logic [47:0] add_capped(input logic [47:0] a, input logic [47:0] b,
                                               input logic [47:0] cap);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, cap}) ? cap : s[47:0];
    endfunction

    function automatic void clear_line_state();
        for (int i = 0; i < 4; i++) ln_base_cnt[i] = '0;
        for (int i = 0; i < 16; i++) ln_pair_cnt[i] = '0;
        ln_len   = '0;
        ln_first = BASE_A;
        ln_clean = 1'b1;
    endfunction

    function automatic void clear_totals();
        for (int i = 0; i < 4; i++) tot_base[i] = '0;
        for (int i = 0; i < 16; i++) tot_pair[i] = '0;
        tot_len   = '0;
        tot_lines = '0;
        tot_sq    = '0;
    endfunction

    // Advance the line/total state by one request; returns 1 when a result is due
    function automatic bit tally_request(input in_req_t r, output out_res_t res);
        logic [7:0]  up;
        logic [1:0]  code;
        bit          hit;
        bit          ok;
        logic [31:0] sq_term;
        logic [47:0] v;
        res = '0;
        case (r.mode)
            MODE_CHAR: begin
                if (ln_len == LEN_CAP) return 1'b0;
                up = r.text_byte;
                if (up >= (CHAR_A | CASE_FOLD) && up <= 8'h7A) up = up - CASE_FOLD;
                hit  = 1'b1;
                code = BASE_A;
                case (up)
                    CHAR_A:  code = BASE_A;
                    CHAR_C:  code = BASE_C;
                    CHAR_T:  code = BASE_T;
                    CHAR_G:  code = BASE_G;
                    default: hit = 1'b0;
                endcase
                if (!hit) begin
                    ln_clean = 1'b0;
                end else begin
                    ln_base_cnt[code]++;
                    if (!ln_len[0]) ln_first = code;
                    else ln_pair_cnt[{ln_first, code}]++;
                end
                ln_len++;
                return 1'b0;
            end
            MODE_EOL: begin
                ok = ln_clean && ln_len != 0 && !ln_len[0] && ln_len != LEN_CAP;
                if (ok) begin
                    for (int i = 0; i < 4; i++)
                        tot_base[i] = 32'(add_capped(48'(tot_base[i]), 48'(ln_base_cnt[i]), CNT_CAP));
                    for (int i = 0; i < 16; i++)
                        tot_pair[i] = 32'(add_capped(48'(tot_pair[i]), 48'(ln_pair_cnt[i]), CNT_CAP));
                    tot_len   = 32'(add_capped(48'(tot_len), 48'(ln_len), CNT_CAP));
                    tot_lines = 32'(add_capped(48'(tot_lines), 48'd1, CNT_CAP));
                    sq_term   = 32'(ln_len) * 32'(ln_len);
                    tot_sq    = add_capped(tot_sq, 48'(sq_term), SQ_CAP);
                end
                res.line_valid  = ok;
                res.line_length = ln_len;
                clear_line_state();
                return 1'b1;
            end
            MODE_READ: begin
                v = '0;
                if (r.counter_index < IDX_PAIR_FIRST) v = 48'(tot_base[r.counter_index[1:0]]);
                else if (r.counter_index <= IDX_PAIR_LAST)
                    v = 48'(tot_pair[4'(r.counter_index - IDX_PAIR_FIRST)]);
                else if (r.counter_index == IDX_BASES) v = 48'(tot_len);
                else if (r.counter_index == IDX_LINES) v = 48'(tot_lines);
                else if (r.counter_index == IDX_SQUARES) v = tot_sq;
                res.counter_value = v;
                return 1'b1;
            end
            default: begin
                clear_totals();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic in_req_t make_req(input logic [1:0] mode, input logic [7:0] ch,
                                         input logic [4:0] idx);
        in_req_t r;
        r.mode          = mode;
        r.text_byte     = ch;
        r.counter_index = idx;
        return r;
    endfunction

    function automatic plan_row_t plan_row(input logic [1:0] mode, input logic [7:0] ch,
                                           input logic [4:0] idx, input bit typed,
                                           input logic valid, input logic [15:0] len,
                                           input logic [47:0] value);
        plan_row_t p;
        p.req                = make_req(mode, ch, idx);
        p.typed              = typed;
        p.want.line_valid    = valid;
        p.want.line_length   = len;
        p.want.counter_value = value;
        return p;
    endfunction

    function automatic logic [7:0] base_char(input logic [1:0] code, input bit lower);
        logic [7:0] c;
        case (code)
            BASE_A:  c = CHAR_A;
            BASE_C:  c = CHAR_C;
            BASE_T:  c = CHAR_T;
            default: c = CHAR_G;
        endcase
        return lower ? (c | CASE_FOLD) : c;
    endfunction

    // Offer one request (called at a falling edge), bursts separated by random gaps
    task automatic send_req(input in_req_t r, input bit typed = 1'b0,
                            input out_res_t want = '0);
        int       idle;
        out_res_t got;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
            if (idle > 0) begin
                s_valid <= 1'b0;
                repeat (idle) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_req   <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (tally_request(r, got)) owed_reports.push_back(typed ? want : got);
        sent_items++;
        @(negedge aclk);
    endtask

    // Stop offering until every owed result is back
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (owed_reports.size() != 0);
    endtask

    task automatic send_bases(input int n);
        for (int k = 0; k < n; k++)
            send_req(make_req(MODE_CHAR, base_char(2'($urandom_range(0, 3)),
                                                   1'($urandom_range(0, 1))),
                              5'($urandom_range(0, 31))));
    endtask

    task automatic send_eol();
        send_req(make_req(MODE_EOL, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31))));
    endtask

    task automatic send_read(input logic [4:0] idx);
        send_req(make_req(MODE_READ, 8'($urandom_range(0, 255)), idx));
    endtask

    // Result checker
    always @(posedge aclk) begin
        out_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual %h", $time, m_res);
            end else begin
                want = owed_reports.pop_front();
                if (m_res.line_valid !== want.line_valid) begin
                    mismatch_count++;
                    $display("%0t: line_valid: expected %0d, actual %0d", $time,
                             want.line_valid, m_res.line_valid);
                end
                if (m_res.line_length !== want.line_length) begin
                    mismatch_count++;
                    $display("%0t: line_length: expected %0d, actual %0d", $time,
                             want.line_length, m_res.line_length);
                end
                if (m_res.counter_value !== want.counter_value) begin
                    mismatch_count++;
                    $display("%0t: counter_value: expected %0d, actual %0d", $time,
                             want.counter_value, m_res.counter_value);
                end
            end
        end
    end

    // Result side: changing stall styles, one long hold on request
    initial begin
        int rx_cycle;
        int style;
        bit hold_seen;
        rx_cycle  = 0;
        style     = 0;
        hold_seen = 1'b0;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_ask && !hold_seen) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_seen = 1'b1;
            end
            if (rx_cycle % 200 == 0) style = $urandom_range(0, 3);
            rx_cycle++;
            case (style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 1);
                2:       m_ready <= (rx_cycle % 4 == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Request side: reset, directed plan, random lines, final readout
    initial begin
        plan_row_t plan [$];
        int        kind;
        int        n;
        bit        hold_done;
        bit        paused;
        hold_done = 1'b0;
        paused    = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_req     = '0;
        clear_line_state();
        clear_totals();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty state, one clean mixed-case line, rejects, clear mid-line
        plan.push_back(plan_row(MODE_READ, 8'h00, IDX_BASES, 1'b1, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_READ, 8'hFF, IDX_SQUARES, 1'b1, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_EOL, 8'h00, 5'd0, 1'b1, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_CHAR, CHAR_A | CASE_FOLD, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_CHAR, CHAR_C | CASE_FOLD, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_CHAR, CHAR_T, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_CHAR, CHAR_G, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_EOL, 8'h00, 5'd0, 1'b1, 1'b1, 16'd4, 48'd0));
        plan.push_back(plan_row(MODE_READ, 8'h00, {3'b0, BASE_A}, 1'b1, 1'b0, 16'd0, 48'd1));
        plan.push_back(plan_row(MODE_READ, 8'h00, IDX_PAIR_FIRST + {BASE_A, BASE_C},
                                1'b1, 1'b0, 16'd0, 48'd1));
        plan.push_back(plan_row(MODE_READ, 8'h00, IDX_PAIR_LAST, 1'b1, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_READ, 8'h00, IDX_SQUARES, 1'b1, 1'b0, 16'd0, 48'd16));
        plan.push_back(plan_row(MODE_READ, 8'h00, IDX_BEYOND, 1'b1, 1'b0, 16'd0, 48'd0));
        // non-base byte spoils an even line
        plan.push_back(plan_row(MODE_CHAR, CHAR_A, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_CHAR, 8'hFF, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_EOL, 8'h00, 5'd0, 1'b1, 1'b0, 16'd2, 48'd0));
        // odd length
        plan.push_back(plan_row(MODE_CHAR, 8'h00, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_EOL, 8'h00, 5'd0, 1'b1, 1'b0, 16'd1, 48'd0));
        // clear keeps the line in progress
        plan.push_back(plan_row(MODE_CHAR, CHAR_G, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_CLEAR, 8'h00, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_CHAR, CHAR_G | CASE_FOLD, 5'd0, 1'b0, 1'b0, 16'd0, 48'd0));
        plan.push_back(plan_row(MODE_EOL, 8'h00, 5'd0, 1'b1, 1'b1, 16'd2, 48'd0));
        plan.push_back(plan_row(MODE_READ, 8'h00, IDX_LINES, 1'b1, 1'b0, 16'd0, 48'd1));
        plan.push_back(plan_row(MODE_READ, 8'h00, IDX_PAIR_LAST, 1'b1, 1'b0, 16'd0, 48'd1));
        plan.push_back(plan_row(MODE_READ, 8'h00, IDX_BASES, 1'b0, 1'b0, 16'd0, 48'd0));
        foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].want);

        // Random: mostly clean lines, some reads, broken lines and clears
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            if (!hold_done && sent_items >= 400) begin
                // reads pile up behind a stalled receiver
                hold_ask = 1'b1;
                repeat (40) send_read(5'($urandom_range(0, 31)));
                hold_done = 1'b1;
            end
            if (!paused && sent_items >= 750) begin
                drain();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_bases(2 * $urandom_range(1, 20));
                send_eol();
                if ($urandom_range(0, 3) == 0) send_read(5'($urandom_range(0, 31)));
            end else if (kind < 80) begin
                send_read(5'($urandom_range(0, 31)));
            end else if (kind < 95) begin
                n = $urandom_range(0, 15);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 5) == 0)
                        send_req(make_req(MODE_CHAR, 8'($urandom_range(0, 255)),
                                          5'($urandom_range(0, 31))));
                    else
                        send_bases(1);
                end
                send_eol();
            end else begin
                send_bases($urandom_range(0, 3));
                send_req(make_req(MODE_CLEAR, 8'($urandom_range(0, 255)),
                                  5'($urandom_range(0, 31))));
                send_bases($urandom_range(0, 3));
                send_eol();
            end
        end

        // Read back every counter index
        for (int k = 0; k < 32; k++) send_read(5'(k));

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/nblc_pkg.sv
rtl/core/nblc_line_acc.sv
rtl/core/nucleotide_bigram_line_counter.sv
sim/testbench.sv
